### sv/stkev_pkg.sv
// Shared constants and types for the stack evaluator.
// Used by the core, the multiply/divide unit and the testbench; no dependencies.
package stkev_pkg;

    localparam int CHAR_W          = 8;
    localparam int VALUE_W         = 64;
    localparam int HALF_W          = 32;
    localparam int STATUS_W        = 3;
    localparam int DEF_STACK_DEPTH = 16;

    // ASCII codes
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FEW   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DIV0  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BADCH = 3'd3;
    localparam logic [STATUS_W-1:0] ST_COUNT = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FULL  = 3'd5;

    // operator codes
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    localparam logic signed [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic signed [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

    // request from the core to the multiply/divide unit
    typedef struct packed {
        logic start;
        logic is_div;
    } t_mdu_req;

endpackage

### sv/rpn_stack_evaluator_core.sv
// Stack evaluator core: one ASCII character per input word, Q31.32 result per expression.
// Digit, space, '+' and '-' are handled in the core; '*' and '/' go through stkev_mdu (96-step divider);
// the last word of an expression then passes through the S_EMIT state to load the output register.
// Throughput: one character at a time; the divider loop sets the worst case.
// Reset (synchronous, active low) empties the stack, clears the error and drops m_axis_tvalid.
// Depends on stkev_pkg, stkev_ram and stkev_mdu.
module rpn_stack_evaluator_core #(
    parameter int STACK_DEPTH = stkev_pkg::DEF_STACK_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [stkev_pkg::CHAR_W-1:0]   s_axis_tdata,  // [7:0] character
    input  logic                           s_axis_tlast,  // end_of_expression
    // result stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [stkev_pkg::VALUE_W-1:0]  m_axis_tdata,  // [63:0] value (Q31.32)
    output logic [stkev_pkg::STATUS_W-1:0] m_axis_tuser   // [2:0] status
);
    import stkev_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_FETCH = 2'd1;   // second operand arriving from RAM
    localparam logic [1:0] S_UNIT  = 2'd2;   // waiting on multiply/divide
    localparam logic [1:0] S_EMIT  = 2'd3;   // load output register

    // Top of stack lives in r_top; entries below it live in the RAM,
    // so a binary op needs one RAM read (entry count-2).
    logic [1:0]                r_state, n_state;
    logic [CW-1:0]             r_count, n_count;
    logic [STATUS_W-1:0]       r_err, n_err;
    logic signed [VALUE_W-1:0] r_top, n_top;
    logic [1:0]                r_op, n_op;
    logic                      r_last, n_last;
    logic                      r_out_valid, n_out_valid;
    logic [VALUE_W-1:0]        r_out_value, n_out_value;
    logic [STATUS_W-1:0]       r_out_status, n_out_status;

    logic                      ram_we;
    logic [AW-1:0]             ram_raddr, ram_waddr;
    logic [VALUE_W-1:0]        ram_rdata;

    t_mdu_req                  mdu_req;
    logic                      mdu_done;
    logic signed [VALUE_W-1:0] mdu_result;

    logic [CW-1:0]             cnt_m1, cnt_m2;
    logic                      accept, is_digit, is_space, is_op;
    logic [1:0]                op_code;
    logic [3:0]                digit;
    logic signed [VALUE_W-1:0] lhs;
    logic [VALUE_W:0]          sum_ext, dif_ext;
    logic signed [VALUE_W-1:0] add_res, sub_res;
    logic [1:0]                fin_state;
    logic [STATUS_W-1:0]       final_status;

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign cnt_m1    = r_count - CW'(1);
    assign cnt_m2    = r_count - CW'(2);
    assign ram_waddr = cnt_m1[AW-1:0];
    assign ram_raddr = cnt_m2[AW-1:0];

    assign is_space = (s_axis_tdata == CH_SPACE);
    assign is_digit = (s_axis_tdata >= CH_ZERO) && (s_axis_tdata <= CH_NINE);
    assign digit    = 4'(s_axis_tdata - CH_ZERO);

    always_comb begin
        is_op   = 1'b1;
        op_code = OP_ADD;
        case (s_axis_tdata)
            CH_PLUS:  op_code = OP_ADD;
            CH_MINUS: op_code = OP_SUB;
            CH_STAR:  op_code = OP_MUL;
            CH_SLASH: op_code = OP_DIV;
            default:  is_op   = 1'b0;
        endcase
    end

    // saturating add / subtract on the fetched pair
    assign lhs     = $signed(ram_rdata);
    assign sum_ext = {lhs[VALUE_W-1], lhs} + {r_top[VALUE_W-1], r_top};
    assign dif_ext = {lhs[VALUE_W-1], lhs} - {r_top[VALUE_W-1], r_top};
    assign add_res = (sum_ext[VALUE_W] != sum_ext[VALUE_W-1])
                   ? (sum_ext[VALUE_W] ? VAL_MIN : VAL_MAX) : $signed(sum_ext[VALUE_W-1:0]);
    assign sub_res = (dif_ext[VALUE_W] != dif_ext[VALUE_W-1])
                   ? (dif_ext[VALUE_W] ? VAL_MIN : VAL_MAX) : $signed(dif_ext[VALUE_W-1:0]);

    // where to go once the current character is fully handled
    assign fin_state = r_last ? S_EMIT : S_IDLE;

    assign final_status = (r_err != ST_OK) ? r_err
                        : (r_count != CW'(1)) ? ST_COUNT : ST_OK;

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_err        = r_err;
        n_top        = r_top;
        n_op         = r_op;
        n_last       = r_last;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;
        ram_we       = 1'b0;
        mdu_req      = '0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_last  = s_axis_tlast;
                    n_state = s_axis_tlast ? S_EMIT : S_IDLE;
                    if (r_err == ST_OK && !is_space) begin
                        if (is_digit) begin
                            if (r_count >= CW'(STACK_DEPTH)) begin
                                n_err = ST_FULL;
                            end else begin
                                // spill old top into RAM, new digit becomes top
                                ram_we  = (r_count != '0);
                                n_top   = $signed({{(VALUE_W-HALF_W-4){1'b0}}, digit,
                                                   {HALF_W{1'b0}}});
                                n_count = r_count + CW'(1);
                            end
                        end else if (r_count < CW'(2)) begin
                            n_err = ST_FEW;
                        end else if (!is_op) begin
                            n_err = ST_BADCH;
                        end else begin
                            // RAM read of entry count-2 issued this cycle
                            n_op    = op_code;
                            n_state = S_FETCH;
                        end
                    end
                end
            end
            S_FETCH: begin
                unique case (r_op)
                    OP_ADD: begin
                        n_top   = add_res;
                        n_count = cnt_m1;
                        n_state = fin_state;
                    end
                    OP_SUB: begin
                        n_top   = sub_res;
                        n_count = cnt_m1;
                        n_state = fin_state;
                    end
                    OP_MUL: begin
                        mdu_req.start = 1'b1;
                        n_state       = S_UNIT;
                    end
                    default: begin
                        if (r_top == '0) begin
                            n_err   = ST_DIV0;
                            n_state = fin_state;
                        end else begin
                            mdu_req.start  = 1'b1;
                            mdu_req.is_div = 1'b1;
                            n_state        = S_UNIT;
                        end
                    end
                endcase
            end
            S_UNIT: begin
                if (mdu_done) begin
                    n_top   = mdu_result;
                    n_count = cnt_m1;
                    n_state = fin_state;
                end
            end
            default: begin
                // wait for the output register to free up, then start a new expression
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = final_status;
                    n_out_value  = (final_status == ST_OK) ? VALUE_W'(r_top) : '0;
                    n_count      = '0;
                    n_err        = ST_OK;
                    n_state      = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_err       <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
        end
        r_top        <= n_top;
        r_op         <= n_op;
        r_last       <= n_last;
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
    end

    stkev_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (VALUE_W'(r_top)),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    stkev_mdu u_mdu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (mdu_req),
        .i_lhs    (lhs),
        .i_rhs    (r_top),
        .o_done   (mdu_done),
        .o_result (mdu_result)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_value;
    assign m_axis_tuser  = r_out_status;

endmodule

### sv/stkev_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module stkev_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/stkev_mdu.sv
// Sequential Q31.32 multiply / divide unit with saturation.
// Depends on stkev_pkg. Multiply: four 32x32 partial products; divide: restoring, 1 bit/cycle.
module stkev_mdu (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  stkev_pkg::t_mdu_req                 i_req,
    input  logic signed [stkev_pkg::VALUE_W-1:0] i_lhs,
    input  logic signed [stkev_pkg::VALUE_W-1:0] i_rhs,
    output logic                                o_done,
    output logic signed [stkev_pkg::VALUE_W-1:0] o_result
);
    import stkev_pkg::*;

    localparam int DIV_STEPS = VALUE_W + HALF_W;   // 96 quotient bits
    localparam int MUL_STEPS = 4;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam int NUM_W     = VALUE_W + HALF_W;
    localparam int ACC_W     = 2 * VALUE_W;

    logic               r_busy, r_div, r_neg, r_done, r_ovf, r_pp_v;
    logic [CNT_W-1:0]   r_cnt;
    logic [VALUE_W-1:0] r_x, r_y, r_rem, r_quo, r_pp;
    logic [1:0]         r_pp_sh;
    logic [NUM_W-1:0]   r_num;
    logic [ACC_W-1:0]   r_acc;

    logic [VALUE_W-1:0] lhs_mag, rhs_mag;
    logic [HALF_W-1:0]  mul_a, mul_b;
    logic [1:0]         mul_sh;
    logic [VALUE_W-1:0] trial;
    logic               trial_ge;
    logic [ACC_W-1:0]   pp_ext;
    logic [VALUE_W-1:0] mag, limit, sat_mag;
    logic               ovf;

    assign lhs_mag = i_lhs[VALUE_W-1] ? VALUE_W'(0) - VALUE_W'(i_lhs) : VALUE_W'(i_lhs);
    assign rhs_mag = i_rhs[VALUE_W-1] ? VALUE_W'(0) - VALUE_W'(i_rhs) : VALUE_W'(i_rhs);

    // partial product select: lo*lo, lo*hi, hi*lo, hi*hi
    always_comb begin
        unique case (r_cnt[1:0])
            2'd0: begin
                mul_a = r_x[HALF_W-1:0];       mul_b = r_y[HALF_W-1:0];       mul_sh = 2'd0;
            end
            2'd1: begin
                mul_a = r_x[HALF_W-1:0];       mul_b = r_y[VALUE_W-1:HALF_W]; mul_sh = 2'd1;
            end
            2'd2: begin
                mul_a = r_x[VALUE_W-1:HALF_W]; mul_b = r_y[HALF_W-1:0];       mul_sh = 2'd1;
            end
            default: begin
                mul_a = r_x[VALUE_W-1:HALF_W]; mul_b = r_y[VALUE_W-1:HALF_W]; mul_sh = 2'd2;
            end
        endcase
    end

    assign pp_ext   = {{VALUE_W{1'b0}}, r_pp} << {r_pp_sh, 5'b0};
    assign trial    = {r_rem[VALUE_W-2:0], r_num[NUM_W-1]};
    assign trial_ge = (trial >= r_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_pp_v <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_div  <= i_req.is_div;
                r_neg  <= i_lhs[VALUE_W-1] ^ i_rhs[VALUE_W-1];
                r_x    <= lhs_mag;
                r_y    <= rhs_mag;
                r_cnt  <= '0;
                r_acc  <= '0;
                r_pp_v <= 1'b0;
                r_num  <= {lhs_mag, {HALF_W{1'b0}}};
                r_rem  <= '0;
                r_quo  <= '0;
                r_ovf  <= 1'b0;
            end else if (r_busy) begin
                if (r_div) begin
                    r_rem <= trial_ge ? trial - r_y : trial;
                    r_quo <= {r_quo[VALUE_W-2:0], trial_ge};
                    r_ovf <= r_ovf | r_quo[VALUE_W-1];
                    r_num <= {r_num[NUM_W-2:0], 1'b0};
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                end else begin
                    if (r_pp_v) begin
                        r_acc <= r_acc + pp_ext;
                    end
                    if (r_cnt < CNT_W'(MUL_STEPS)) begin
                        r_pp    <= VALUE_W'(mul_a * mul_b);
                        r_pp_sh <= mul_sh;
                        r_pp_v  <= 1'b1;
                        r_cnt   <= r_cnt + CNT_W'(1);
                    end else begin
                        r_pp_v <= 1'b0;
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                end
            end
        end
    end

    // saturate magnitude to Q31.32 and apply sign
    assign mag     = r_div ? r_quo : r_acc[VALUE_W+HALF_W-1:HALF_W];
    assign ovf     = r_div ? r_ovf : (|r_acc[ACC_W-1:VALUE_W+HALF_W]);
    assign limit   = r_neg ? VALUE_W'(VAL_MIN) : VALUE_W'(VAL_MAX);
    assign sat_mag = (ovf || mag > limit) ? limit : mag;

    assign o_done   = r_done;
    assign o_result = r_neg ? $signed(VALUE_W'(0) - sat_mag) : $signed(sat_mag);

endmodule

### tb/tb_top.sv
// Self-checking bench for rpn_stack_evaluator_core: streams expression characters in,
// predicts each final value/status in Q31.32 and compares every output word in order.
// Depends on stkev_pkg and the core RTL only.
`timescale 1ns / 100ps

module tb_top;
    import stkev_pkg::*;

    localparam int DEPTH = DEF_STACK_DEPTH;

    typedef struct packed {
        logic              last;
        logic [CHAR_W-1:0] ch;
    } t_char_word;

    typedef struct packed {
        logic [VALUE_W-1:0]  value;
        logic [STATUS_W-1:0] status;
    } t_calc_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [CHAR_W-1:0]   s_axis_tdata = '0;
    logic                s_axis_tlast = 1'b0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [VALUE_W-1:0]  m_axis_tdata;
    logic [STATUS_W-1:0] m_axis_tuser;

    rpn_stack_evaluator_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [7:0] character
        .s_axis_tlast  (s_axis_tlast),   // end_of_expression
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [63:0] value
        .m_axis_tuser  (m_axis_tuser)    // [2:0] status
    );

    // stimulus and expectation stores
    t_char_word   char_fifo[$];
    t_calc_result result_fifo[$];
    logic [CHAR_W-1:0] expr_buf[$];

    int  words_total = 0;
    int  words_taken = 0;
    int  err_cnt = 0;
    int  cyc = 0;
    bit  word_taken = 0;
    bit  hold_off = 0;

    // shadow evaluator state
    logic signed [VALUE_W-1:0] shadow_stack [DEPTH];
    int unsigned               shadow_cnt;
    logic [STATUS_W-1:0]       shadow_err;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

    // ---------------- arithmetic ----------------
    function automatic logic [VALUE_W-1:0] abs64(logic signed [VALUE_W-1:0] x);
        return x[VALUE_W-1] ? VALUE_W'(-x) : x;
    endfunction

    // clamp a wide magnitude to Q31.32 and apply the sign
    function automatic logic signed [VALUE_W-1:0] clamp_signed(logic [127:0] mag, logic neg);
        logic [127:0] lim;
        lim = neg ? (128'd1 << 63) : (128'd1 << 63) - 128'd1;
        if (mag > lim)
            mag = lim;
        return neg ? VALUE_W'(64'd0 - mag[63:0]) : mag[63:0];
    endfunction

    function automatic logic signed [VALUE_W-1:0] fix_add(logic signed [VALUE_W-1:0] a,
                                                          logic signed [VALUE_W-1:0] b,
                                                          bit subtract);
        logic signed [VALUE_W:0] s;
        s = subtract ? {a[VALUE_W-1], a} - {b[VALUE_W-1], b}
                     : {a[VALUE_W-1], a} + {b[VALUE_W-1], b};
        if (s[VALUE_W] != s[VALUE_W-1])
            return s[VALUE_W] ? VAL_MIN : VAL_MAX;
        return s[VALUE_W-1:0];
    endfunction

    function automatic logic signed [VALUE_W-1:0] fix_mul(logic signed [VALUE_W-1:0] a,
                                                          logic signed [VALUE_W-1:0] b);
        logic [127:0] p;
        p = {64'd0, abs64(a)} * {64'd0, abs64(b)};
        return clamp_signed(p >> HALF_W, a[VALUE_W-1] ^ b[VALUE_W-1]);
    endfunction

    // divisor must be nonzero
    function automatic logic signed [VALUE_W-1:0] fix_div(logic signed [VALUE_W-1:0] a,
                                                          logic signed [VALUE_W-1:0] b);
        logic [127:0] n;
        n = {64'd0, abs64(a)} << HALF_W;
        return clamp_signed(n / {64'd0, abs64(b)}, a[VALUE_W-1] ^ b[VALUE_W-1]);
    endfunction

    // feed one character to the shadow evaluator; queue a result on the last one
    task automatic eval_char(logic [CHAR_W-1:0] ch, logic last);
        logic signed [VALUE_W-1:0] lhs, rhs, res;
        t_calc_result r;
        bit ok;
        if (shadow_err == ST_OK && ch != CH_SPACE) begin
            if (ch >= CH_ZERO && ch <= CH_NINE) begin
                if (shadow_cnt >= DEPTH) begin
                    shadow_err = ST_FULL;
                end else begin
                    shadow_stack[shadow_cnt] = {24'd0, 8'(ch - CH_ZERO), 32'd0};
                    shadow_cnt++;
                end
            end else if (shadow_cnt < 2) begin
                shadow_err = ST_FEW;   // also covers a bad char on a short stack
            end else begin
                rhs = shadow_stack[shadow_cnt-1];
                lhs = shadow_stack[shadow_cnt-2];
                ok  = 1;
                res = '0;
                case (ch)
                    CH_PLUS:  res = fix_add(lhs, rhs, 0);
                    CH_MINUS: res = fix_add(lhs, rhs, 1);
                    CH_STAR:  res = fix_mul(lhs, rhs);
                    CH_SLASH: begin
                        if (rhs == 0) begin
                            shadow_err = ST_DIV0;
                            ok = 0;
                        end else begin
                            res = fix_div(lhs, rhs);
                        end
                    end
                    default: begin
                        shadow_err = ST_BADCH;
                        ok = 0;
                    end
                endcase
                if (ok) begin
                    shadow_cnt--;
                    shadow_stack[shadow_cnt-1] = res;
                end
            end
        end
        if (last) begin
            r.status = shadow_err;
            if (r.status == ST_OK && shadow_cnt != 1)
                r.status = ST_COUNT;
            r.value = (r.status == ST_OK) ? shadow_stack[0] : '0;
            result_fifo = {result_fifo, r};
            shadow_cnt = 0;
            shadow_err = ST_OK;
        end
    endtask

    // ---------------- stimulus builders ----------------
    function automatic logic [CHAR_W-1:0] op_char(int k);
        case (k)
            0:       return CH_PLUS;
            1:       return CH_MINUS;
            2:       return CH_STAR;
            default: return CH_SLASH;
        endcase
    endfunction

    function automatic logic [CHAR_W-1:0] digit_char(int d);
        return CH_ZERO + CHAR_W'(d);
    endfunction

    task automatic emit_buf();
        t_char_word w;
        foreach (expr_buf[i]) begin
            w.last = (i == expr_buf.size() - 1);
            w.ch   = expr_buf[i];
            char_fifo = {char_fifo, w};
            words_total++;
        end
        expr_buf.delete();
    endtask

    task automatic emit_text(string s);
        for (int i = 0; i < s.len(); i++)
            expr_buf = {expr_buf, CHAR_W'(s[i])};
        emit_buf();
    endtask

    task automatic add_token(logic [CHAR_W-1:0] ch);
        if ($urandom_range(99) < 20)
            expr_buf = {expr_buf, CH_SPACE};
        expr_buf = {expr_buf, ch};
    endtask

    // random valid expression with n operands, never deeper than n
    task automatic build_wellformed(int n);
        int pushes_left, depth;
        pushes_left = n;
        depth = 0;
        while (pushes_left > 0 || depth > 1) begin
            if (pushes_left > 0 && (depth < 2 || $urandom_range(99) < 55)) begin
                add_token(digit_char($urandom_range(9)));
                pushes_left--;
                depth++;
            end else begin
                add_token(op_char($urandom_range(3)));
                depth--;
            end
        end
        if ($urandom_range(99) < 10)
            expr_buf = {expr_buf, CH_SPACE};
    endtask

    // drive toward the Q31.32 limits, then poke at the saturated value
    task automatic build_saturating();
        add_token(digit_char(9));
        repeat ($urandom_range(9, 13)) begin
            add_token(digit_char(9));
            add_token(CH_STAR);
        end
        case ($urandom_range(3))
            0: ;
            1: begin add_token(digit_char(9)); add_token(CH_PLUS); end
            2: begin   // divide by 1/9
                add_token(digit_char(1)); add_token(digit_char(9));
                add_token(CH_SLASH); add_token(CH_SLASH);
            end
            default: begin   // flip to the negative limit
                add_token(digit_char(0)); add_token(digit_char(9));
                add_token(CH_MINUS); add_token(CH_STAR);
                add_token(digit_char(9)); add_token(CH_MINUS);
            end
        endcase
    endtask

    task automatic build_overfull();
        repeat (DEPTH + $urandom_range(1, 3))
            add_token(digit_char($urandom_range(9)));
        repeat ($urandom_range(3))
            add_token(op_char($urandom_range(3)));
    endtask

    task automatic build_broken();
        int idx;
        build_wellformed($urandom_range(2, 6));
        idx = $urandom_range(expr_buf.size() - 1);
        case ($urandom_range(2))
            0:       expr_buf[idx] = CHAR_W'($urandom_range(255));
            1:       if (expr_buf.size() > 1) expr_buf.delete(idx);
            default: expr_buf = {expr_buf, op_char($urandom_range(3))};
        endcase
    endtask

    function automatic int pick_size();
        int p;
        p = $urandom_range(99);
        if (p < 70) return $urandom_range(1, 5);
        if (p < 95) return $urandom_range(6, 12);
        return $urandom_range(13, DEPTH);
    endfunction

    // ---------------- main sequence ----------------
    initial begin
        int pick;
        // directed: one operand, subtract, multiply and divide, div by zero, short stack,
        // bad char (full and short stack), empty and unfinished expressions,
        // error latching
        emit_text("0");
        emit_text("98-");
        emit_text("34*");
        emit_text("72/");
        emit_text("30/");
        emit_text("+");
        expr_buf = '{8'h31, 8'h32, 8'hFF};
        emit_buf();
        expr_buf = '{8'h31, 8'h00};
        emit_buf();
        emit_text(" ");
        emit_text("12");
        emit_text("+5");

        while (words_total < 830) begin
            pick = $urandom_range(99);
            if (pick < 68)
                build_wellformed(pick_size());
            else if (pick < 74)
                build_saturating();
            else if (pick < 80)
                build_overfull();
            else if (pick < 90)
                build_broken();
            else
                repeat ($urandom_range(1, 8))
                    expr_buf = {expr_buf, CHAR_W'($urandom_range(255))};
            emit_buf();
        end

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (words_taken < words_total || result_fifo.size() != 0)
            @(negedge i_clk);
        // divider worst case plus output register
        repeat (200) @(posedge i_clk);

        if (err_cnt == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    // long receiver hold-off so the core backs up into its input
    initial begin
        @(posedge i_rst_n);
        while (words_taken < 300)
            @(posedge i_clk);
        hold_off = 1;
        repeat (500) @(posedge i_clk);
        hold_off = 0;
    end

    // ---------------- drivers ----------------
    function automatic bit quiet_window();
        return cyc >= 2000 && cyc < 6000;
    endfunction

    always @(negedge i_clk) begin
        t_char_word w;
        if (i_rst_n && (!s_axis_tvalid || word_taken)) begin
            word_taken = 0;
            if (char_fifo.size() > 0 && (quiet_window() || $urandom_range(99) >= 34)) begin
                w = char_fifo.pop_front();
                s_axis_tdata  <= w.ch;
                s_axis_tlast  <= w.last;
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        m_axis_tready <= i_rst_n && !hold_off && (quiet_window() || $urandom_range(99) >= 34);
    end

    // ---------------- monitor ----------------
    always @(posedge i_clk) begin
        t_calc_result want;
        if (!i_rst_n) begin
            shadow_cnt = 0;
            shadow_err = ST_OK;
        end else begin
            cyc++;
            if (s_axis_tvalid && s_axis_tready) begin
                word_taken = 1;
                words_taken++;
                eval_char(s_axis_tdata, s_axis_tlast);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (result_fifo.size() == 0) begin
                    err_cnt++;
                    $display("%0t: unexpected result value=%h status=%0d",
                             $time, m_axis_tdata, m_axis_tuser);
                end else begin
                    want = result_fifo.pop_front();
                    if (m_axis_tdata !== want.value) begin
                        err_cnt++;
                        $display("%0t: value mismatch expected=%h actual=%h",
                                 $time, want.value, m_axis_tdata);
                    end
                    if (m_axis_tuser !== want.status) begin
                        err_cnt++;
                        $display("%0t: status mismatch expected=%0d actual=%0d",
                                 $time, want.status, m_axis_tuser);
                    end
                end
            end
        end
    end

endmodule
